// File: src/qmcm_pkg.sv
// ----------------------------------------------------------------------------
// qmcm_pkg: shared constants
// Field widths, request and register codes, and the exp(-x) step table used
// by the mask coefficient MAC unit and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package qmcm_pkg;

    // field widths
    localparam int CH_W     = 6;
    localparam int COEFF_W  = 16;
    localparam int SAMPLE_W = 8;
    localparam int LOGIT_W  = 16;
    localparam int PROB_W   = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // request kinds
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMOID  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 8'd3;

    // register reset values
    localparam logic [15:0] SCALE_RST    = 16'd256;
    localparam logic [7:0]  ZERO_RST     = 8'd0;
    localparam logic        SIGMOID_RST  = 1'b1;
    localparam logic [6:0]  CHANNELS_RST = 7'd32;

    // exp(-2^(i-8)) in Q0.16, one entry per logit magnitude bit
    function automatic logic [15:0] exp_k(input logic [3:0] idx);
        logic [15:0] k;
        case (idx)
            4'd0:    k = 16'd65280;
            4'd1:    k = 16'd65026;
            4'd2:    k = 16'd64520;
            4'd3:    k = 16'd63520;
            4'd4:    k = 16'd61565;
            4'd5:    k = 16'd57835;
            4'd6:    k = 16'd51039;
            4'd7:    k = 16'd39750;
            4'd8:    k = 16'd24109;
            4'd9:    k = 16'd8869;
            4'd10:   k = 16'd1200;
            default: k = 16'd0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// File: src/qmcm_if.sv
// ----------------------------------------------------------------------------
// qmcm_if: channel interfaces of the mask coefficient MAC unit
// Request stream, result stream and register write channel, each a
// valid/ready channel with a source and a sink modport.
// ----------------------------------------------------------------------------
`default_nettype none

// request stream: coefficient loads and proto samples
interface qmcm_req_if;
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic [qmcm_pkg::CH_W-1:0]        channel_index;
    logic signed [qmcm_pkg::COEFF_W-1:0]  coeff_value;
    logic signed [qmcm_pkg::SAMPLE_W-1:0] sample_value;

    modport source (output valid, output req_type, output channel_index,
                    output coeff_value, output sample_value, input ready);
    modport sink   (input valid, input req_type, input channel_index,
                    input coeff_value, input sample_value, output ready);
endinterface

// result stream: one item per finished pixel
interface qmcm_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [qmcm_pkg::LOGIT_W-1:0] logit_value;
    logic [qmcm_pkg::PROB_W-1:0]         probability;

    modport source (output valid, output logit_value, output probability, input ready);
    modport sink   (input valid, input logit_value, input probability, output ready);
endinterface

// register write channel
interface qmcm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [qmcm_pkg::CFG_IDX_W-1:0]    index;
    logic [qmcm_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/quantized_mask_coefficient_mac_unit.sv
// ----------------------------------------------------------------------------
// quantized_mask_coefficient_mac_unit: mask coefficient MAC with sigmoid
// Loads Q4.12 coefficients into a store and sums zero-point corrected int8
// proto samples times their coefficients; the last channel gives a Q8.8
// logit and an optional 8-bit probability.
// ----------------------------------------------------------------------------
// Usage
//   req: coefficient loads (req_type 0) and proto samples (req_type 1).
//   rsp: one item per pixel, on the sample of the last channel.
//   cfg: register writes, always ready; write only while the unit is idle.
// Sequence
//   A load is written while idle. A sample that is not the last of its pixel
//   steps through coefficient read, multiply and accumulate. The last sample
//   goes on through scale, round and the sigmoid check to the result register
//   with sigmoid off or saturated; otherwise it also passes the exp(-x) multiply
//   chain, the divider set-up and the bit-per-cycle divider of the probability.
//   One item is worked on at a time; req.ready is high only when idle.
// Reset
//   Registers take their reset values and the running sum is cleared. The
//   coefficient store is not cleared; load every used channel first.
// Stall
//   A result waits in the output register; the unit keeps taking requests
//   and only holds before writing the next result into a full register.
// ----------------------------------------------------------------------------
`default_nettype none

module quantized_mask_coefficient_mac_unit #(
    parameter int MAX_CHANNELS = 64
) (
    input  wire     clk,
    input  wire     rst_n,
    qmcm_req_if.sink    req,
    qmcm_rsp_if.source  rsp,
    qmcm_cfg_if.sink    cfg
);
    import qmcm_pkg::*;

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [8:0] MAX_CNT = 9'(MAX_CHANNELS);

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_ACC   = 4'd2;
    localparam logic [3:0] ST_SCALE = 4'd3;
    localparam logic [3:0] ST_RND   = 4'd4;
    localparam logic [3:0] ST_SIG   = 4'd5;
    localparam logic [3:0] ST_EXP   = 4'd6;
    localparam logic [3:0] ST_DSET  = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;

    // coefficient store
    logic [COEFF_W-1:0] coeff_mem [MAX_CHANNELS];
    logic signed [COEFF_W-1:0] coef_rd_reg;

    // registers
    logic [3:0]         state_reg, state_next;
    logic signed [8:0]  centered_reg, centered_next;
    logic               last_reg, last_next;
    logic signed [24:0] prod_reg, prod_next;
    logic [31:0]        sum_reg, sum_next;
    logic signed [48:0] scaled_reg, scaled_next;
    logic signed [15:0] logit_reg, logit_next;
    logic [10:0]        mag_reg, mag_next;
    logic [16:0]        e_reg, e_next;
    logic [3:0]         idx_reg, idx_next;
    logic [25:0]        rem_reg, rem_next;
    logic [18:0]        dvsr_reg, dvsr_next;
    logic [3:0]         k_reg, k_next;
    logic [8:0]         quot_reg, quot_next;
    logic [7:0]         prob_reg, prob_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] out_logit_reg, out_logit_next;
    logic [7:0]         out_prob_reg, out_prob_next;
    logic [15:0]        scale_reg;
    logic [7:0]         zero_reg;
    logic               sig_en_reg;
    logic [6:0]         count_reg;

    // combinational helpers
    logic               req_xfer;
    logic [8:0]         cnt_eff;
    logic [8:0]         ch_ext;
    logic               load_hit;
    logic               sample_hit;
    logic [AW-1:0]      mem_addr;
    logic signed [49:0] rounded;
    logic signed [29:0] shifted;
    logic signed [16:0] logit_ext;
    logic [16:0]        logit_mag;
    logic [32:0]        exp_prod;
    logic [17:0]        dsum;
    logic [26:0]        trial;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid       = out_valid_reg;
    assign rsp.logit_value = out_logit_reg;
    assign rsp.probability = out_prob_reg;

    // effective channel count: 0 acts as 1, clipped to the store depth
    always_comb
    begin
        cnt_eff = (count_reg == 7'd0) ? 9'd1 : 9'(count_reg);
        if (cnt_eff > MAX_CNT)
        begin
            cnt_eff = MAX_CNT;
        end
    end

    assign ch_ext     = 9'(req.channel_index);
    assign mem_addr   = AW'(req.channel_index);
    assign load_hit   = req_xfer && (req.req_type == REQ_LOAD) && (ch_ext < MAX_CNT);
    assign sample_hit = req_xfer && (req.req_type == REQ_SAMPLE) && (ch_ext < cnt_eff);

    // store write on a load, registered read on a sample
    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            coeff_mem[mem_addr] <= req.coeff_value;
        end
        if (sample_hit)
        begin
            coef_rd_reg <= coeff_mem[mem_addr];
        end
    end

    // datapath helpers
    assign rounded   = 50'(scaled_reg) + 50'sd524288;
    assign shifted   = 30'(rounded >>> 20);
    assign logit_ext = 17'(logit_reg);
    assign logit_mag = logit_ext[16] ? 17'(-logit_ext) : 17'(logit_ext);
    assign exp_prod  = e_reg * exp_k(idx_reg) + 33'd32768;
    assign dsum      = 18'(e_reg) + 18'd65536;
    assign trial     = 27'(dvsr_reg) << k_reg;

    // sequencer and datapath next values
    always_comb
    begin
        state_next     = state_reg;
        centered_next  = centered_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        scaled_next    = scaled_reg;
        logit_next     = logit_reg;
        mag_next       = mag_reg;
        e_next         = e_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;
        dvsr_next      = dvsr_reg;
        k_next         = k_reg;
        quot_next      = quot_reg;
        prob_next      = prob_reg;
        out_logit_next = out_logit_reg;
        out_prob_next  = out_prob_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_hit)
                begin
                    centered_next = 9'(req.sample_value) - 9'($signed(zero_reg));
                    last_next     = (ch_ext == cnt_eff - 9'd1);
                    state_next    = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = centered_reg * coef_rd_reg;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                sum_next   = sum_reg + 32'(prod_reg);
                state_next = last_reg ? ST_SCALE : ST_IDLE;
            end
            ST_SCALE:
            begin
                scaled_next = $signed(sum_reg) * $signed({1'b0, scale_reg});
                state_next  = ST_RND;
            end
            ST_RND:
            begin
                // floor((sum * scale + 2^19) / 2^20), saturated to Q8.8
                if (shifted > 30'sd32767)
                begin
                    logit_next = 16'sh7fff;
                end
                else if (shifted < -30'sd32768)
                begin
                    logit_next = 16'sh8000;
                end
                else
                begin
                    logit_next = 16'(shifted);
                end
                sum_next   = 32'd0;
                state_next = ST_SIG;
            end
            ST_SIG:
            begin
                if (!sig_en_reg)
                begin
                    prob_next  = 8'd0;
                    state_next = ST_FIN;
                end
                else if (logit_mag >= 17'd2048)
                begin
                    prob_next  = logit_reg[15] ? 8'd0 : 8'd255;
                    state_next = ST_FIN;
                end
                else
                begin
                    mag_next   = logit_mag[10:0];
                    e_next     = 17'd65536;
                    idx_next   = 4'd0;
                    state_next = ST_EXP;
                end
            end
            ST_EXP:
            begin
                // one magnitude bit per cycle
                if (mag_reg[idx_reg])
                begin
                    e_next = exp_prod[32:16];
                end
                if (idx_reg == 4'd10)
                begin
                    state_next = ST_DSET;
                end
                else
                begin
                    idx_next = idx_reg + 4'd1;
                end
            end
            ST_DSET:
            begin
                dvsr_next = {dsum, 1'b0};
                if (logit_reg[15])
                begin
                    rem_next = 26'(e_reg) * 26'd510 + 26'(dsum);
                end
                else
                begin
                    rem_next = 26'd33423360 + 26'(dsum);
                end
                quot_next  = 9'd0;
                k_next     = 4'd8;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                if ({1'b0, rem_reg} >= trial)
                begin
                    rem_next  = rem_reg - trial[25:0];
                    quot_next = quot_reg | (9'd1 << k_reg);
                end
                if (k_reg == 4'd0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    k_next = k_reg - 4'd1;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_logit_next = logit_reg;
                    out_prob_next  = sig_en_reg && (logit_mag < 17'd2048) ? quot_reg[7:0]
                                                                          : prob_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
            scale_reg     <= SCALE_RST;
            zero_reg      <= ZERO_RST;
            sig_en_reg    <= SIGMOID_RST;
            count_reg     <= CHANNELS_RST;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_SCALE:    scale_reg  <= cfg.data;
                    CFG_ZERO:     zero_reg   <= cfg.data[7:0];
                    CFG_SIGMOID:  sig_en_reg <= cfg.data[0];
                    CFG_CHANNELS: count_reg  <= cfg.data[6:0];
                    default:      ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        centered_reg  <= centered_next;
        last_reg      <= last_next;
        prod_reg      <= prod_next;
        scaled_reg    <= scaled_next;
        logit_reg     <= logit_next;
        mag_reg       <= mag_next;
        e_reg         <= e_next;
        idx_reg       <= idx_next;
        rem_reg       <= rem_next;
        dvsr_reg      <= dvsr_next;
        k_reg         <= k_next;
        quot_reg      <= quot_next;
        prob_reg      <= prob_next;
        out_logit_reg <= out_logit_next;
        out_prob_reg  <= out_prob_next;
    end

    // the running sum starts every pixel from zero
    a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RND) |=> (sum_reg == 32'd0))
        else $error("running sum not cleared after pixel");

    // exp(-x) never grows above 1.0
    a_exp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXP) |-> (e_reg <= 17'd65536))
        else $error("exp chain above one");

    // the probability quotient fits in eight bits
    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && k_reg == 4'd0) |=> (quot_reg[8] == 1'b0))
        else $error("probability quotient overflow");

    // a result is only written when the output register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && out_valid_reg && !rsp.ready) |=> (state_reg == ST_FIN))
        else $error("result written over a pending one");

endmodule

`default_nettype wire

// File: verif/tb_quantized_mask_coefficient_mac_unit.sv
// ----------------------------------------------------------------------------
// tb_quantized_mask_coefficient_mac_unit: self-checking bench for the MAC unit
// Drives coefficient loads and proto samples with random gaps, stalls the
// result stream at random, and checks each pixel's logit and probability
// against an in-bench fixed-point predictor across several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_quantized_mask_coefficient_mac_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import qmcm_pkg::*;

    localparam int MAX_CH         = 64;
    localparam int GAP_MAX        = 12;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RAND_PHASES    = 14;
    localparam int PHASE_ITEMS    = 122;

    // register indexes outside the defined map; writes there must do nothing
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_LO = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_HI = 8'd255;

    // exp(-2^(i-8)) steps in Q0.16
    localparam longint unsigned EXP_STEP [11] = '{
        65280, 65026, 64520, 63520, 61565, 57835,
        51039, 39750, 24109, 8869, 1200
    };

    // channel_count per random phase: extremes, out-of-range and small sizes
    localparam int CH_PLAN [RAND_PHASES] = '{4, 1, 8, 64, 3, 0, 2, 127, 6, 5, 16, 2, 65, 3};
    localparam int IDLE_PCT [3] = '{0, 10, 35};

    typedef struct {
        logic                       kind;
        logic [CH_W-1:0]            ch;
        logic signed [COEFF_W-1:0]  coeff;
        logic signed [SAMPLE_W-1:0] sample;
    } mac_req_t;

    typedef struct {
        logic signed [LOGIT_W-1:0] logit;
        logic [PROB_W-1:0]         prob;
    } pixel_t;

    logic clk;
    logic rst_n;

    qmcm_req_if req_ch ();
    qmcm_rsp_if rsp_ch ();
    qmcm_cfg_if cfg_ch ();

    quantized_mask_coefficient_mac_unit #(
        .MAX_CHANNELS (MAX_CH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // predictor state
    logic signed [COEFF_W-1:0]  coeff_mem [MAX_CH];
    logic signed [31:0]         acc_sum = '0;
    logic [15:0]                reg_scale = SCALE_RST;
    logic signed [7:0]          reg_zero = ZERO_RST;
    logic                       reg_sigmoid = SIGMOID_RST;
    logic [6:0]                 reg_channels = CHANNELS_RST;

    // stimulus and checking state
    mac_req_t    pending_reqs [$];
    pixel_t      expected_pixels [$];
    mac_req_t    on_bus;
    bit          coeff_loaded [MAX_CH];
    int unsigned gen_count = 0;
    int unsigned mismatches = 0;
    int          quiet_cycles = 0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // effective channel count: 0 acts as 1, above the store acts as full
    function automatic int unsigned active_channels();
        int unsigned n;
        n = reg_channels;
        if (n == 0)
            n = 1;
        if (n > MAX_CH)
            n = MAX_CH;
        return n;
    endfunction

    // round(255 * sigmoid(logit)) from the Q8.8 logit
    function automatic logic [PROB_W-1:0] sigmoid_prob(input logic signed [LOGIT_W-1:0] logit);
        int               mag;
        int               i;
        longint unsigned  e;
        longint unsigned  d;
        mag = (logit < 0) ? -int'(logit) : int'(logit);
        if (mag >= 2048)
            return (logit > 0) ? 8'd255 : 8'd0;
        e = 65536;
        for (i = 0; i < 11; i++)
        begin
            if (mag[i])
                e = (e * EXP_STEP[i] + 32768) >> 16;
        end
        d = 65536 + e;
        if (logit >= 0)
            return PROB_W'((longint'(2 * 255 * 65536) + d) / (2 * d));
        return PROB_W'((2 * 255 * e + d) / (2 * d));
    endfunction

    // update predictor on an accepted request; closes a pixel on the last channel
    task automatic predict_mac(input mac_req_t it);
        int unsigned n;
        int          centered;
        longint      scaled;
        pixel_t      px;
        if (it.kind == REQ_LOAD)
        begin
            coeff_mem[it.ch] = it.coeff;
            return;
        end
        n = active_channels();
        if (it.ch >= n)
            return;
        centered = int'(it.sample) - int'(reg_zero);
        acc_sum = acc_sum + 32'(centered * int'(coeff_mem[it.ch]));
        if (it.ch != n - 1)
            return;
        scaled = (longint'(acc_sum) * longint'(reg_scale) + (longint'(1) <<< 19)) >>> 20;
        if (scaled > 32767)
            scaled = 32767;
        if (scaled < -32768)
            scaled = -32768;
        px.logit = LOGIT_W'(scaled);
        px.prob  = reg_sigmoid ? sigmoid_prob(px.logit) : '0;
        acc_sum  = '0;
        expected_pixels.push_back(px);
    endtask

    // random coefficient: half full range, half small for sigmoid coverage
    function automatic logic [COEFF_W-1:0] rand_coeff();
        if ($urandom_range(0, 1) == 0)
            return COEFF_W'($urandom);
        return COEFF_W'(int'($urandom_range(0, 4095)) - 2048);
    endfunction

    task automatic push_load(input int unsigned ch, input logic [COEFF_W-1:0] value);
        mac_req_t it;
        it.kind   = REQ_LOAD;
        it.ch     = CH_W'(ch);
        it.coeff  = value;
        it.sample = SAMPLE_W'($urandom);
        pending_reqs.push_back(it);
        coeff_loaded[ch] = 1'b1;
        gen_count++;
    endtask

    // sample; a channel in range that was never loaded gets a coefficient first
    task automatic push_sample(input int unsigned ch, input logic [SAMPLE_W-1:0] value);
        mac_req_t it;
        if (ch < active_channels() && !coeff_loaded[ch])
            push_load(ch, rand_coeff());
        it.kind   = REQ_SAMPLE;
        it.ch     = CH_W'(ch);
        it.coeff  = COEFF_W'($urandom);
        it.sample = value;
        pending_reqs.push_back(it);
        if (ch < active_channels())
            gen_count++;
    endtask

    // one register write transfer; predictor follows at the transfer
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_SCALE:    reg_scale = value;
            CFG_ZERO:     reg_zero = value[7:0];
            CFG_SIGMOID:  reg_sigmoid = value[0];
            CFG_CHANNELS: reg_channels = value[6:0];
            default:      ;
        endcase
    endtask

    // all four registers; unused upper data bits carry random junk
    task automatic set_regs(input logic [15:0] scale, input logic [7:0] zero,
                            input logic sig, input logic [6:0] chans);
        cfg_write(CFG_SCALE, scale);
        cfg_write(CFG_ZERO, {8'($urandom), zero});
        cfg_write(CFG_SIGMOID, {15'($urandom), sig});
        cfg_write(CFG_CHANNELS, {9'($urandom), chans});
    endtask

    // wait for all requests and results, then let the datapath go quiet
    task automatic drain();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly whole pixels with random content, plus loads, stray and broken samples
    task automatic random_traffic(input int unsigned target);
        int unsigned n;
        int unsigned start;
        int unsigned ch;
        n = active_channels();
        start = gen_count;
        while (gen_count - start < target)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                for (ch = 0; ch < n; ch++)
                begin
                    if ($urandom_range(0, 15) == 0)
                        push_load($urandom_range(0, MAX_CH - 1), rand_coeff());
                    push_sample(ch, SAMPLE_W'($urandom));
                end
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: push_load($urandom_range(0, MAX_CH - 1), rand_coeff());
                    1: push_sample($urandom_range((n < MAX_CH) ? n : 0, MAX_CH - 1),
                                   SAMPLE_W'($urandom));
                    default: push_sample($urandom_range(0, n - 1), SAMPLE_W'($urandom));
                endcase
            end
        end
    endtask

    // request driver: holds each item until its transfer, random gaps between
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid         <= 1'b0;
            req_ch.req_type      <= REQ_LOAD;
            req_ch.channel_index <= '0;
            req_ch.coeff_value   <= '0;
            req_ch.sample_value  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                predict_mac(on_bus);
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    on_bus = pending_reqs.pop_front();
                    req_ch.valid         <= 1'b1;
                    req_ch.req_type      <= on_bus.kind;
                    req_ch.channel_index <= on_bus.ch;
                    req_ch.coeff_value   <= on_bus.coeff;
                    req_ch.sample_value  <= on_bus.sample;
                    if ($urandom_range(1, 100) <= send_idle_pct)
                        send_gap = $urandom_range(1, GAP_MAX);
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: random ready stalls, checks each transfer in order
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected result: expected none, actual logit %0d prob %0d",
                             $time, rsp_ch.logit_value, rsp_ch.probability);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (rsp_ch.logit_value !== want.logit)
                    begin
                        mismatches++;
                        $display("%0t logit mismatch: expected %0d actual %0d",
                                 $time, want.logit, rsp_ch.logit_value);
                    end
                    if (rsp_ch.probability !== want.prob)
                    begin
                        mismatches++;
                        $display("%0t probability mismatch: expected %0d actual %0d",
                                 $time, want.prob, rsp_ch.probability);
                    end
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(1, 100) <= recv_stall_pct)
                    stall_left = $urandom_range(1, GAP_MAX);
            end
        end
    end

    // watchdog: too long without any transfer on any channel
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t watchdog: no transfer for %0d cycles", $time, quiet_cycles);
            $display("tb_quantized_mask_coefficient_mac_unit NOT OK");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus sequence
    initial
    begin
        int          phase_no;
        logic [15:0] scale;
        logic [7:0]  zero;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = REQ_LOAD;
        req_ch.channel_index = '0;
        req_ch.coeff_value   = '0;
        req_ch.sample_value  = '0;
        rsp_ch.ready         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // extreme coefficients and samples, a stray channel, a lone last channel
        set_regs(16'd256, 8'h00, 1'b1, 7'd2);
        push_load(0, 16'h7FFF);
        push_load(1, 16'h8000);
        push_sample(0, 8'h7F);
        push_sample(1, 8'h80);
        push_sample(63, 8'h00);
        push_sample(1, 8'h55);
        push_load(2, 16'h0000);
        push_sample(0, 8'h00);
        push_sample(1, 8'h00);
        drain();

        // channel count zero acts as one; full scale, most negative zero point
        set_regs(16'hFFFF, 8'h80, 1'b0, 7'd0);
        push_sample(0, 8'h7F);
        push_sample(0, 8'h80);
        push_sample(1, 8'hAA);
        drain();

        // zero scale gives logit zero
        set_regs(16'h0000, 8'h7F, 1'b1, 7'd1);
        push_sample(0, 8'h80);
        push_sample(0, 8'h7F);
        drain();

        // saturation both ways; writes to undefined indexes are dropped
        set_regs(16'hFFFF, 8'h00, 1'b1, 7'd2);
        cfg_write(CFG_NONE_LO, 16'($urandom));
        cfg_write(CFG_NONE_HI, 16'($urandom));
        push_load(0, 16'h8000);
        push_load(1, 16'h8000);
        push_sample(0, 8'h80);
        push_sample(1, 8'h80);
        push_sample(0, 8'h7F);
        push_sample(1, 8'h7F);
        drain();

        // random phases, each under its own register setting
        for (phase_no = 0; phase_no < RAND_PHASES; phase_no++)
        begin
            if (phase_no >= RAND_PHASES - 2)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            else
            begin
                send_idle_pct  = IDLE_PCT[$urandom_range(0, 2)];
                recv_stall_pct = IDLE_PCT[$urandom_range(0, 2)];
            end
            case (phase_no % 4)
                0:       scale = 16'($urandom_range(1, 65535));
                1:       scale = 16'($urandom_range(1, 512));
                2:       scale = (phase_no % 8 == 2) ? 16'd1 : 16'hFFFF;
                default: scale = 16'($urandom_range(16, 4096));
            endcase
            if (phase_no == 3)
                zero = 8'h80;
            else if (phase_no == 5)
                zero = 8'h7F;
            else
                zero = 8'($urandom);
            set_regs(scale, zero, (phase_no % 3) != 2, 7'(CH_PLAN[phase_no]));
            if (phase_no == 7)
                cfg_write(CFG_NONE_LO, 16'($urandom));
            random_traffic(PHASE_ITEMS);
            drain();
        end

        if (mismatches == 0)
            $display("tb_quantized_mask_coefficient_mac_unit OK");
        else
            $display("tb_quantized_mask_coefficient_mac_unit NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
